// File: hdl/first_divisor_sieve_table_unit_macros.svh
// Assertion macros shared by the sieve table checker.
`ifndef FIRST_DIVISOR_SIEVE_TABLE_UNIT_MACROS_SVH
`define FIRST_DIVISOR_SIEVE_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FDST_ASSERT_IMP(lbl, clk, rst_n, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FDST_ASSERT_NXT(lbl, clk, rst_n, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// File: hdl/fdst_pkg.sv
// Shared constants and function codes of the first-divisor sieve table.
package fdst_pkg;

    localparam int FUNC_W  = 2;
    localparam int VALUE_W = 12;
    localparam int IDX_W   = 12;
    localparam int ENTRY_W = IDX_W + 1;

    localparam int DEF_MAX_VALUE    = 4095;
    localparam int DEF_MAX_ELEMENTS = 4096;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

endpackage

// File: hdl/fdst_req_if.sv
// Request channel: function code and value, valid/ready handshake.
interface fdst_req_if
    import fdst_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

// File: hdl/fdst_rsp_if.sv
// Response channel: found flag, element index and status, valid/ready handshake.
interface fdst_rsp_if
    import fdst_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             found;
    logic [IDX_W-1:0] element_index;
    logic             status;

    modport source (output valid, output found, output element_index, output status,
                    input ready);
    modport sink   (input valid, input found, input element_index, input status,
                    output ready);
endinterface

// File: hdl/first_divisor_sieve_table_unit.sv
// Top level of the first-divisor sieve table.
// Usage:
//   req carries func and value; rsp returns found, element_index and status,
//   one response item per request item, in order. Both use valid/ready.
//   Query: one RAM read (states QRD, QDAT), then FIN loads the result; a
//   query of zero or of a value above MAX_VALUE skips the read.
//   Add: the shared address adder walks one multiple per cycle through
//   the table RAM, from value up to MAX_VALUE, then DRAIN and FIN. A
//   rejected add, an add above MAX_VALUE or an unknown func goes to FIN.
//   Clear: one RAM entry written per cycle, 0 to MAX_VALUE, then FIN.
//   req.ready is high only while no item is in progress, so one item at a time.
//   After reset the block sweeps the table once, entry 0 to MAX_VALUE, with
//   req.ready low; the element count is zero afterwards.
//   The response sits in an output register: the next request is taken while
//   a response waits, and if rsp.ready stays low, the following result is held
//   internally and the block stalls until the output register frees up.
module first_divisor_sieve_table_unit
    import fdst_pkg::*;
#(
    parameter int MAX_VALUE    = DEF_MAX_VALUE,
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
    input  logic      clk,
    input  logic      rst_n,
    fdst_req_if.sink  req,
    fdst_rsp_if.source rsp
);
    localparam int ADDR_W = $clog2(MAX_VALUE + 1);
    localparam int M_W    = ((ADDR_W > VALUE_W) ? ADDR_W : VALUE_W) + 1;
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);

    localparam logic [M_W-1:0]   MAXV  = M_W'(MAX_VALUE);
    localparam logic [CNT_W-1:0] MAXE  = CNT_W'(MAX_ELEMENTS);

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_QRD,
        ST_QDAT,
        ST_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [M_W-1:0]    m_reg, m_next;
    logic [M_W-1:0]    step_reg, step_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic              p_vld_reg, p_vld_next;
    logic [ADDR_W-1:0] p_addr_reg, p_addr_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              found_reg, found_next;
    logic              status_reg, status_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_found_reg, out_found_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic              out_status_reg, out_status_next;

    logic [M_W-1:0]    step_sel;
    logic [M_W-1:0]    gen_sum;
    logic              gen_past_end;
    logic [M_W-1:0]    value_ext;
    logic              acc;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic              rd_en;
    logic [ENTRY_W-1:0] rd_data;

    assign step_sel  = (state_reg == ST_SWEEP) ? M_W'(1) : step_reg;
    assign value_ext = M_W'(req.value);
    assign req.ready = (state_reg == ST_IDLE);
    assign acc       = req.valid && req.ready;

    fdst_addr_gen #(
        .MAX_VALUE (MAX_VALUE),
        .M_W       (M_W)
    ) u_fdst_addr_gen (
        .base     (m_reg),
        .step     (step_sel),
        .sum      (gen_sum),
        .past_end (gen_past_end)
    );

    always_comb
    begin
        if (state_reg == ST_SWEEP)
        begin
            wr_en   = 1'b1;
            wr_addr = m_reg[ADDR_W-1:0];
            wr_data = '0;
        end
        else
        begin
            wr_en   = p_vld_reg && !rd_data[IDX_W];
            wr_addr = p_addr_reg;
            wr_data = {1'b1, idx_reg};
        end
    end

    assign rd_en = (state_reg == ST_WALK) || (state_reg == ST_QRD);

    fdst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_VALUE + 1),
        .AW    (ADDR_W)
    ) u_fdst_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (m_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        m_next          = m_reg;
        step_next       = step_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        p_vld_next      = 1'b0;
        p_addr_next     = p_addr_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_found_next  = out_found_reg;
        out_idx_next    = out_idx_reg;
        out_status_next = out_status_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_SWEEP:
            begin
                cnt_next = '0;
                m_next   = gen_sum;
                if (gen_past_end)
                begin
                    state_next = pend_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (acc)
                begin
                    found_next  = 1'b0;
                    idx_next    = '0;
                    status_next = 1'b0;
                    state_next  = ST_FIN;
                    case (req.func)
                        FUNC_CLEAR:
                        begin
                            pend_next  = 1'b1;
                            m_next     = '0;
                            state_next = ST_SWEEP;
                        end
                        FUNC_ADD:
                        begin
                            if (req.value == '0 || cnt_reg >= MAXE)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                found_next = 1'b1;
                                idx_next   = IDX_W'(cnt_reg);
                                cnt_next   = cnt_reg + CNT_W'(1);
                                m_next     = value_ext;
                                step_next  = value_ext;
                                if (value_ext <= MAXV)
                                begin
                                    state_next = ST_WALK;
                                end
                            end
                        end
                        FUNC_QUERY:
                        begin
                            if (req.value != '0 && value_ext <= MAXV)
                            begin
                                m_next     = value_ext;
                                state_next = ST_QRD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                p_vld_next  = 1'b1;
                p_addr_next = m_reg[ADDR_W-1:0];
                m_next      = gen_sum;
                if (gen_past_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_QRD:
            begin
                state_next = ST_QDAT;
            end
            ST_QDAT:
            begin
                found_next = rd_data[IDX_W];
                idx_next   = rd_data[IDX_W-1:0];
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = found_reg;
                    out_idx_next    = idx_reg;
                    out_status_next = status_reg;
                    pend_next       = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            m_reg         <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            p_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            m_reg         <= m_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            p_vld_reg     <= p_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg       <= step_next;
        p_addr_reg     <= p_addr_next;
        idx_reg        <= idx_next;
        found_reg      <= found_next;
        status_reg     <= status_next;
        out_found_reg  <= out_found_next;
        out_idx_reg    <= out_idx_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.found         = out_found_reg;
    assign rsp.element_index = out_idx_reg;
    assign rsp.status        = out_status_reg;
endmodule

// File: hdl/fdst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fdst_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// File: hdl/fdst_addr_gen.sv
// Shared address adder and end-of-table compare for sweeps and multiple walks.
module fdst_addr_gen #(
    parameter int MAX_VALUE = 4095,
    parameter int M_W       = 13
) (
    input  logic [M_W-1:0] base,
    input  logic [M_W-1:0] step,
    output logic [M_W-1:0] sum,
    output logic           past_end
);
    localparam logic [M_W-1:0] LIMIT = M_W'(MAX_VALUE);

    assign sum      = base + step;
    assign past_end = (sum > LIMIT);
endmodule

// File: hdl/fdst_checker.sv
// Port-level checker for the sieve table, bound to the top level.
`include "first_divisor_sieve_table_unit_macros.svh"

module fdst_checker
    import fdst_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic             rsp_found,
    input logic [IDX_W-1:0] rsp_index,
    input logic             rsp_status
);
    `FDST_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid, "rsp item dropped while stalled")
    `FDST_ASSERT_NXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready, "request taken while item in progress")
    `FDST_ASSERT_IMP(a_reject_zero, clk, rst_n, rsp_valid && rsp_status, !rsp_found && rsp_index == '0, "rejected add carries a result")
    `FDST_ASSERT_IMP(a_found_ok, clk, rst_n, rsp_valid && rsp_found, !rsp_status, "found item flagged as rejected")
endmodule

bind first_divisor_sieve_table_unit fdst_checker u_fdst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_found  (rsp.found),
    .rsp_index  (rsp.element_index),
    .rsp_status (rsp.status)
);
